FILE: rtl/hol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hol_pkg
// Shared types, constants and character helpers for the object line loader.
// ----------------------------------------------------------------------------
package hol_pkg;

  // Line geometry.
  localparam int unsigned COL_KEPT    = 30;  // columns held in the line store
  localparam int unsigned COL_LATE    = 28;  // first column of a comment bar
  localparam int unsigned BAR_OFFSET  = 23;  // bar column past the colon
  localparam int unsigned COL_DATA    = 7;   // first data column
  localparam int unsigned MAX_BYTES   = 10;  // data bytes on one line

  localparam logic [2:0] COLON_NONE = 3'd7;
  localparam logic [4:0] BAR_NONE   = 5'd30;
  localparam logic [4:0] BAR_FAR    = 5'd31;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // Result kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Input actions.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // Line status codes.
  localparam logic [2:0] LS_COMMENT = 3'd0;
  localparam logic [2:0] LS_BLANK   = 3'd1;
  localparam logic [2:0] LS_DATA    = 3'd2;
  localparam logic [2:0] LS_ERROR   = 3'd3;
  localparam logic [2:0] LS_IGNORED = 3'd4;

  // Input word.
  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } hol_in_t;

  // Result word.
  typedef struct packed {
    logic        kind;
    logic [16:0] write_address;
    logic [7:0]  write_byte;
    logic [2:0]  line_status;
    logic [15:0] line_number;
    logic        last;
  } hol_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WRITE,
    S_STATUS
  } hol_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_char;
    logic eval;
    logic emit_write;
    logic emit_status;
  } hol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic has_writes;
    logic last_write;
  } hol_sts_t;

  // True for a lowercase hex digit.
  function automatic logic is_hex(input logic [7:0] ch);
    return ((ch >= 8'h30) && (ch <= 8'h39)) || ((ch >= 8'h61) && (ch <= 8'h66));
  endfunction

  // Value of a lowercase hex digit; only meaningful when is_hex holds.
  function automatic logic [3:0] hex_nib(input logic [7:0] ch);
    return ch[6] ? (ch[3:0] + 4'd9) : ch[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hex_object_line_loader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_object_line_loader
// Checks a fixed-column hex object listing and turns its data lines into
// memory byte writes, one status word per line.
// ----------------------------------------------------------------------------
// Line characters are taken one word per cycle while the loader is idle and
// produce no result. An end-of-line word starts the evaluation step, then the
// write step emits one write per data byte (up to ten), or passes empty when
// the line has no bytes, and then the status word is emitted. Each write and
// the status word wait while the output is stalled. The single output register
// holds each result, and no new word is taken until the status word has been
// loaded into it. Line characters are accepted while an earlier status word
// still waits at the output. After the first format error every later line
// reports ignored until reset.
module hex_object_line_loader (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  hol_pkg::hol_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output hol_pkg::hol_out_t out_data
);

  hol_pkg::hol_cmd_t cmd;
  hol_pkg::hol_sts_t sts;
  logic              in_eol;

  assign in_eol = in_data.action == hol_pkg::ACT_EOL;

  // Sequencer.
  hol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eol   (in_eol),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  hol_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/hol_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hol_ctrl
// Sequencer: takes characters, runs the end-of-line evaluation and steps the
// datapath through the byte writes and the status word.
// ----------------------------------------------------------------------------
module hol_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_eol,
  output logic              in_stall,
  input  hol_pkg::hol_sts_t sts,
  output hol_pkg::hol_cmd_t cmd
);

  hol_pkg::hol_state_t state_r;
  hol_pkg::hol_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hol_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hol_pkg::S_IDLE: begin
        if (in_valid && in_eol) state_nxt = hol_pkg::S_EVAL;
      end
      hol_pkg::S_EVAL: begin
        state_nxt = hol_pkg::S_WRITE;
      end
      hol_pkg::S_WRITE: begin
        if (!sts.has_writes) begin
          state_nxt = hol_pkg::S_STATUS;
        end else if (sts.out_free && sts.last_write) begin
          state_nxt = hol_pkg::S_STATUS;
        end
      end
      hol_pkg::S_STATUS: begin
        if (sts.out_free) state_nxt = hol_pkg::S_IDLE;
      end
      default: state_nxt = hol_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      hol_pkg::S_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_char = in_valid && !in_eol;
      end
      hol_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
      end
      hol_pkg::S_WRITE: begin
        cmd.emit_write = sts.has_writes && sts.out_free;
      end
      hol_pkg::S_STATUS: begin
        cmd.emit_status = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/hol_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hol_dp
// Datapath: line store and column trackers, end-of-line classification,
// byte queue for the writes and the output register.
// ----------------------------------------------------------------------------
module hol_dp (
  input  wire               clk,
  input  wire               rst_n,
  input  hol_pkg::hol_in_t  in_data,
  input  hol_pkg::hol_cmd_t cmd,
  output hol_pkg::hol_sts_t sts,
  input  wire               out_stall,
  output logic              out_valid,
  output hol_pkg::hol_out_t out_data
);

  localparam int unsigned NCOL = hol_pkg::COL_KEPT;
  localparam int unsigned NB   = hol_pkg::MAX_BYTES;
  localparam int unsigned NRUN = 2 * NB;

  // Line state.
  logic [7:0]  chars_r [NCOL];
  logic [7:0]  column_r;
  logic [2:0]  colon_r;
  logic [4:0]  fbar_r;
  logic [4:0]  lbar_r;
  logic        spc_r;

  // State kept across lines.
  logic [16:0] next_addr_r;
  logic        err_r;
  logic [15:0] lines_r;

  // Emit state.
  logic [16:0] wr_addr_r;
  logic [7:0]  bytes_r [NB];
  logic [3:0]  left_r;
  logic [2:0]  status_r;

  // Output register.
  logic              out_valid_r;
  hol_pkg::hol_out_t out_data_r;

  // Classification signals.
  logic [NCOL-1:0] vld;
  logic [NCOL-1:0] hx;
  logic [NCOL-1:0] sp;
  logic [NRUN:0]   pre;
  logic            run;
  logic [15:0]     addr16;
  logic            addr_form;
  logic            addr_ok;
  logic [4:0]      bar_exp;
  logic [3:0]      cnt;
  logic            blank;
  logic            comment;
  logic [2:0]      eval_status;
  logic [7:0]      dec_byte [NB];
  logic [7:0]      ch;
  logic [7:0]      p;

  assign ch = in_data.char_code;
  assign p  = column_r;

  // Per-column flags: a column past the line end is neither hex nor space.
  always_comb begin
    for (int i = 0; i < NCOL; i++) begin
      vld[i] = column_r > 8'(i);
      hx[i]  = vld[i] && hol_pkg::is_hex(chars_r[i]);
      sp[i]  = vld[i] && (chars_r[i] == hol_pkg::CH_SPACE);
    end
  end

  // Address field, colon at column 5 or 6.
  always_comb begin
    addr16 = (colon_r == 3'd6) ?
             {hol_pkg::hex_nib(chars_r[2]), hol_pkg::hex_nib(chars_r[3]),
              hol_pkg::hex_nib(chars_r[4]), hol_pkg::hex_nib(chars_r[5])} :
             {4'h0, hol_pkg::hex_nib(chars_r[2]), hol_pkg::hex_nib(chars_r[3]),
              hol_pkg::hex_nib(chars_r[4])};
    addr_form = ((colon_r == 3'd5) || (colon_r == 3'd6)) &&
                vld[0] && (chars_r[0] == hol_pkg::CH_ZERO) &&
                vld[1] && (chars_r[1] == hol_pkg::CH_X) &&
                hx[2] && hx[3] && hx[4] && ((colon_r != 3'd6) || hx[5]);
    bar_exp = {2'b00, colon_r} + 5'(hol_pkg::BAR_OFFSET);
    addr_ok = addr_form && ({1'b0, addr16} >= next_addr_r) && (lbar_r == bar_exp);
  end

  // Data byte count: the longest even hex run from column 7 ended by a space.
  always_comb begin
    run    = 1'b1;
    pre[0] = 1'b1;
    for (int j = 0; j < NRUN; j++) begin
      run      = run & hx[hol_pkg::COL_DATA + j];
      pre[j+1] = run;
    end
    cnt = '0;
    for (int n = 1; n <= NB; n++) begin
      if (pre[2*n] && sp[hol_pkg::COL_DATA + 2*n]) cnt = 4'(n);
    end
    if (sp[hol_pkg::COL_DATA]) cnt = '0;
  end

  // Blank line: all spaces from past the colon up to the first bar.
  always_comb begin
    blank = 1'b1;
    for (int j = 0; j < NCOL; j++) begin
      if ((5'(j) > {2'b00, colon_r}) && (5'(j) < fbar_r) && !sp[j]) blank = 1'b0;
    end
  end

  // Decoded data bytes at their fixed column pairs.
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      dec_byte[k] = {hol_pkg::hex_nib(chars_r[hol_pkg::COL_DATA + 2*k]),
                     hol_pkg::hex_nib(chars_r[hol_pkg::COL_DATA + 2*k + 1])};
    end
  end

  // Line status.
  always_comb begin
    comment = (lbar_r != hol_pkg::BAR_NONE) && spc_r;
    if (err_r) begin
      eval_status = hol_pkg::LS_IGNORED;
    end else if (comment) begin
      eval_status = hol_pkg::LS_COMMENT;
    end else if (addr_ok && blank) begin
      eval_status = hol_pkg::LS_BLANK;
    end else if (addr_ok && (cnt != 4'd0)) begin
      eval_status = hol_pkg::LS_DATA;
    end else begin
      eval_status = hol_pkg::LS_ERROR;
    end
  end

  // Line store; only the first columns are kept.
  always_ff @(posedge clk) begin
    if (cmd.take_char && (column_r < 8'(NCOL))) begin
      chars_r[column_r[4:0]] <= ch;
    end
  end

  // Column trackers; cleared once the line has been evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.eval) begin
      column_r <= '0;
      colon_r  <= hol_pkg::COLON_NONE;
      fbar_r   <= hol_pkg::BAR_NONE;
      lbar_r   <= hol_pkg::BAR_NONE;
      spc_r    <= 1'b1;
    end else if (cmd.take_char) begin
      if ((ch == hol_pkg::CH_COLON) && (colon_r == hol_pkg::COLON_NONE) &&
          (p < 8'd7)) begin
        colon_r <= p[2:0];
      end
      if ((ch == hol_pkg::CH_BAR) && (fbar_r == hol_pkg::BAR_NONE) &&
          (p < 8'(NCOL))) begin
        fbar_r <= p[4:0];
      end
      if (lbar_r == hol_pkg::BAR_NONE) begin
        if ((ch == hol_pkg::CH_BAR) && (p >= 8'(hol_pkg::COL_LATE))) begin
          lbar_r <= (p < 8'(NCOL)) ? p[4:0] : hol_pkg::BAR_FAR;
        end else if (ch != hol_pkg::CH_SPACE) begin
          spc_r <= 1'b0;
        end
      end
      if (column_r != 8'hff) column_r <= column_r + 8'd1;
    end
  end

  // Cross-line state: expected address, error flag, line count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r <= '0;
      err_r       <= 1'b0;
      lines_r     <= '0;
    end else if (cmd.eval) begin
      if (lines_r != 16'hffff) lines_r <= lines_r + 16'd1;
      if ((eval_status == hol_pkg::LS_BLANK) || (eval_status == hol_pkg::LS_DATA)) begin
        next_addr_r <= {1'b0, addr16} + 17'(cnt);
      end
      if (eval_status == hol_pkg::LS_ERROR) err_r <= 1'b1;
    end
  end

  // Emit queue: loaded at evaluation, shifted one byte per write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cmd.eval) begin
      left_r <= (eval_status == hol_pkg::LS_DATA) ? cnt : 4'd0;
    end else if (cmd.emit_write) begin
      left_r <= left_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r  <= eval_status;
      wr_addr_r <= {1'b0, addr16};
      for (int k = 0; k < NB; k++) bytes_r[k] <= dec_byte[k];
    end else if (cmd.emit_write) begin
      wr_addr_r <= wr_addr_r + 17'd1;
      for (int k = 0; k < NB - 1; k++) bytes_r[k] <= bytes_r[k+1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_write || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_write) begin
      out_data_r.kind          <= hol_pkg::KIND_WRITE;
      out_data_r.write_address <= wr_addr_r;
      out_data_r.write_byte    <= bytes_r[0];
      out_data_r.line_status   <= hol_pkg::LS_DATA;
      out_data_r.line_number   <= lines_r;
      out_data_r.last          <= 1'b0;
    end else if (cmd.emit_status) begin
      out_data_r.kind          <= hol_pkg::KIND_STATUS;
      out_data_r.write_address <= '0;
      out_data_r.write_byte    <= '0;
      out_data_r.line_status   <= status_r;
      out_data_r.line_number   <= lines_r;
      out_data_r.last          <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.has_writes = left_r != 4'd0;
  assign sts.last_write = left_r == 4'd1;

endmodule
`default_nettype wire
